FILE: rtl/jtsp_pkg.sv
package jtsp_pkg;

    // default stack depth, handed down from the top level
    localparam int STACK_DEPTH_DEF = 64;

    // depth of the request queue between front and back
    localparam int Q_DEPTH = 2;

    localparam int LEN_W   = 16;
    localparam int KIND_W  = 4;
    localparam int CODE_W  = 4;
    localparam int STAT_W  = 3;

    // context codes held on the stack
    localparam logic [CODE_W-1:0] ST_VALUE     = 4'd0;
    localparam logic [CODE_W-1:0] ST_PARTIAL   = 4'd1;
    localparam logic [CODE_W-1:0] ST_OBJ_NEW   = 4'd2;
    localparam logic [CODE_W-1:0] ST_OBJ_KEY   = 4'd3;
    localparam logic [CODE_W-1:0] ST_OBJ_COLON = 4'd4;
    localparam logic [CODE_W-1:0] ST_OBJ_VALUE = 4'd5;
    localparam logic [CODE_W-1:0] ST_OBJ_NEXT  = 4'd6;
    localparam logic [CODE_W-1:0] ST_ARR_NEW   = 4'd7;
    localparam logic [CODE_W-1:0] ST_ARR_ITEM  = 4'd8;
    localparam logic [CODE_W-1:0] ST_ARR_NEXT  = 4'd9;

    // token kinds
    localparam logic [KIND_W-1:0] TK_NUMBER    = 4'd4;
    localparam logic [KIND_W-1:0] TK_STRING    = 4'd3;
    localparam logic [KIND_W-1:0] TK_OBJ_OPEN  = 4'd5;
    localparam logic [KIND_W-1:0] TK_OBJ_CLOSE = 4'd6;
    localparam logic [KIND_W-1:0] TK_ARR_OPEN  = 4'd7;
    localparam logic [KIND_W-1:0] TK_ARR_CLOSE = 4'd8;
    localparam logic [KIND_W-1:0] TK_COLON     = 4'd9;
    localparam logic [KIND_W-1:0] TK_COMMA     = 4'd10;

    // event kinds
    localparam logic [KIND_W-1:0] EV_OBJ_END = 4'd6;
    localparam logic [KIND_W-1:0] EV_ARR_END = 4'd8;
    localparam logic [KIND_W-1:0] EV_NONE    = 4'd9;

    // status codes
    localparam logic [STAT_W-1:0] S_OK       = 3'd0;
    localparam logic [STAT_W-1:0] S_MORE     = 3'd1;
    localparam logic [STAT_W-1:0] S_INVALID  = 3'd2;
    localparam logic [STAT_W-1:0] S_BADKEY   = 3'd3;
    localparam logic [STAT_W-1:0] S_DEEP     = 3'd4;
    localparam logic [STAT_W-1:0] S_INTERNAL = 3'd5;
    localparam logic [STAT_W-1:0] S_UNCL_OBJ = 3'd6;
    localparam logic [STAT_W-1:0] S_UNCL_ARR = 3'd7;

    // token class flags decoded by the front
    typedef struct packed {
        logic scalar;
        logic key_str;
        logic obj_open;
        logic obj_close;
        logic arr_open;
        logic arr_close;
        logic colon;
        logic comma;
    } tok_class_t;

    // one request as it travels through the queue
    typedef struct packed {
        logic              func;
        logic [KIND_W-1:0] kind;
        logic              part;
        logic [LEN_W-1:0]  len;
        tok_class_t        cls;
    } req_t;

    // end-of-input scan: S_OK means skip this entry and go on downward
    function automatic logic [STAT_W-1:0] ctx_scan_status(input logic [CODE_W-1:0] code);
        logic [STAT_W-1:0] s;
        unique case (code)
            ST_VALUE, ST_PARTIAL:                          s = S_OK;
            ST_OBJ_NEW, ST_OBJ_KEY, ST_OBJ_COLON,
            ST_OBJ_VALUE, ST_OBJ_NEXT:                     s = S_UNCL_OBJ;
            ST_ARR_NEW, ST_ARR_ITEM, ST_ARR_NEXT:          s = S_UNCL_ARR;
            default:                                       s = S_INTERNAL;
        endcase
        return s;
    endfunction

endpackage

FILE: rtl/jtsp_front.sv
module jtsp_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [15:0]            s_axis_tdata,
    input  logic [7:0]             s_axis_tuser,
    output jtsp_pkg::req_t         q_data,
    output logic                   q_valid,
    input  logic                   q_pop
);
    import jtsp_pkg::*;

    localparam int QPW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int QCW = $clog2(Q_DEPTH + 1);

    req_t             req_in;
    req_t             q_mem [Q_DEPTH];
    logic [QPW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [QPW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    logic             push;

    // classify the incoming token
    always_comb
    begin
        req_in.func          = s_axis_tuser[0];
        req_in.kind          = s_axis_tuser[4:1];
        req_in.part          = s_axis_tuser[5];
        req_in.len           = s_axis_tdata;
        req_in.cls.scalar    = (req_in.kind <= TK_NUMBER);
        req_in.cls.key_str   = (req_in.kind == TK_STRING);
        req_in.cls.obj_open  = (req_in.kind == TK_OBJ_OPEN);
        req_in.cls.obj_close = (req_in.kind == TK_OBJ_CLOSE);
        req_in.cls.arr_open  = (req_in.kind == TK_ARR_OPEN);
        req_in.cls.arr_close = (req_in.kind == TK_ARR_CLOSE);
        req_in.cls.colon     = (req_in.kind == TK_COLON);
        req_in.cls.comma     = (req_in.kind == TK_COMMA);
    end

    assign s_axis_tready = (cnt_reg != QCW'(Q_DEPTH));
    assign push          = s_axis_tvalid && s_axis_tready;
    assign q_valid       = (cnt_reg != '0);
    assign q_data        = q_mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPW'(Q_DEPTH - 1)) ? '0 : wr_ptr_reg + QPW'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPW'(Q_DEPTH - 1)) ? '0 : rd_ptr_reg + QPW'(1);
        end
        if (push && !q_pop)
        begin
            cnt_next = cnt_reg + QCW'(1);
        end
        else if (!push && q_pop)
        begin
            cnt_next = cnt_reg - QCW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= req_in;
        end
    end

endmodule

FILE: rtl/jtsp_back.sv
module jtsp_back #(
    parameter int STACK_DEPTH = jtsp_pkg::STACK_DEPTH_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  jtsp_pkg::req_t q_data,
    input  logic           q_valid,
    output logic           q_pop,
    output logic           m_axis_tvalid,
    input  logic           m_axis_tready,
    output logic [15:0]    m_axis_tdata,
    output logic [7:0]     m_axis_tuser
);
    import jtsp_pkg::*;

    localparam int AW = $clog2(STACK_DEPTH);
    localparam int TW = $clog2(STACK_DEPTH + 1);

    localparam logic [1:0] BK_IDLE    = 2'd0;
    localparam logic [1:0] BK_EXEC    = 2'd1;
    localparam logic [1:0] BK_SCAN_RD = 2'd2;
    localparam logic [1:0] BK_SCAN_EV = 2'd3;

    logic [1:0]        state_reg, state_next;
    logic [TW-1:0]     top_reg, top_next;
    logic [CODE_W-1:0] cache_reg, cache_next;   // entry at top - 1
    req_t              req_reg, req_next;
    logic [AW-1:0]     scan_reg, scan_next;

    logic [CODE_W-1:0] ctx_mem [STACK_DEPTH];   // entries below the cached top
    logic [CODE_W-1:0] rd_data_reg;
    logic              rd_en, wr_en;
    logic [AW-1:0]     rd_addr, wr_addr;
    logic [CODE_W-1:0] wr_data;

    logic              out_valid_reg, out_valid_next;
    logic [KIND_W-1:0] out_ev_reg;
    logic [STAT_W-1:0] out_st_reg;
    logic [LEN_W-1:0]  out_len_reg;
    logic              ld;
    logic [KIND_W-1:0] ld_ev;
    logic [STAT_W-1:0] ld_st;
    logic [LEN_W-1:0]  ld_len;
    logic              out_free;

    logic              top_ok, at_full;
    logic [TW-1:0]     top_m1, top_m2;

    // token decode results
    logic              x_res, do_value, push_req, pop;
    logic [KIND_W-1:0] x_ev;
    logic [STAT_W-1:0] x_st;
    logic [CODE_W-1:0] set_code, push_code;
    logic [STAT_W-1:0] sc;

    assign top_ok   = (top_reg != '0) && (top_reg <= TW'(STACK_DEPTH));
    assign at_full  = (top_reg >= TW'(STACK_DEPTH));
    assign top_m1   = top_reg - TW'(1);
    assign top_m2   = top_reg - TW'(2);
    assign out_free = !out_valid_reg || m_axis_tready;

    // token against the context on top of the stack
    always_comb
    begin
        x_res     = 1'b1;
        x_ev      = EV_NONE;
        x_st      = S_OK;
        do_value  = 1'b0;
        push_req  = 1'b0;
        push_code = ST_PARTIAL;
        pop       = 1'b0;
        set_code  = cache_reg;
        if (!top_ok)
        begin
            x_st = S_INTERNAL;
        end
        else
        begin
            unique case (cache_reg)
                ST_VALUE:
                begin
                    do_value = 1'b1;
                end
                ST_PARTIAL:
                begin
                    pop = !req_reg.part;
                    if (req_reg.cls.scalar)
                    begin
                        x_ev = req_reg.kind;
                        x_st = {2'b00, req_reg.part};
                    end
                    else
                    begin
                        x_st = S_INTERNAL;
                    end
                end
                ST_OBJ_NEW, ST_OBJ_NEXT:
                begin
                    if (cache_reg == ST_OBJ_NEW && req_reg.cls.obj_close)
                    begin
                        pop  = 1'b1;
                        x_ev = EV_OBJ_END;
                    end
                    else if (req_reg.cls.key_str)
                    begin
                        x_ev     = req_reg.kind;
                        set_code = ST_OBJ_KEY;
                        x_st     = {2'b00, req_reg.part};
                        push_req = req_reg.part;
                    end
                    else
                    begin
                        x_st = S_BADKEY;
                    end
                end
                ST_OBJ_KEY:
                begin
                    if (req_reg.cls.colon)
                    begin
                        set_code = ST_OBJ_COLON;
                        x_res    = 1'b0;
                    end
                    else
                    begin
                        x_st = S_INVALID;
                    end
                end
                ST_OBJ_COLON:
                begin
                    set_code = ST_OBJ_VALUE;
                    do_value = 1'b1;
                end
                ST_OBJ_VALUE:
                begin
                    if (req_reg.cls.comma)
                    begin
                        set_code = ST_OBJ_NEXT;
                        x_res    = 1'b0;
                    end
                    else if (req_reg.cls.obj_close)
                    begin
                        pop  = 1'b1;
                        x_ev = EV_OBJ_END;
                    end
                    else
                    begin
                        x_st = S_INVALID;
                    end
                end
                ST_ARR_ITEM:
                begin
                    if (req_reg.cls.comma)
                    begin
                        set_code = ST_ARR_NEXT;
                        x_res    = 1'b0;
                    end
                    else if (req_reg.cls.arr_close)
                    begin
                        pop  = 1'b1;
                        x_ev = EV_ARR_END;
                    end
                    else
                    begin
                        x_st = S_INVALID;
                    end
                end
                ST_ARR_NEW:
                begin
                    if (req_reg.cls.arr_close)
                    begin
                        pop  = 1'b1;
                        x_ev = EV_ARR_END;
                    end
                    else
                    begin
                        set_code = ST_ARR_ITEM;
                        do_value = 1'b1;
                    end
                end
                ST_ARR_NEXT:
                begin
                    set_code = ST_ARR_ITEM;
                    do_value = 1'b1;
                end
                default:
                begin
                    x_st = S_INTERNAL;
                end
            endcase
        end

        // a value is expected here
        if (do_value)
        begin
            if (req_reg.cls.scalar)
            begin
                x_ev     = req_reg.kind;
                x_st     = {2'b00, req_reg.part};
                push_req = req_reg.part;
            end
            else if (req_reg.cls.obj_open || req_reg.cls.arr_open)
            begin
                x_ev      = req_reg.kind;
                x_st      = {2'b00, req_reg.part};
                push_req  = 1'b1;
                push_code = req_reg.cls.obj_open ? ST_OBJ_NEW : ST_ARR_NEW;
            end
            else
            begin
                x_st = S_INVALID;
            end
        end

        if (push_req && at_full)
        begin
            x_st = S_DEEP;
        end
        if (x_st >= S_INVALID)
        begin
            x_ev = EV_NONE;
        end
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        top_next   = top_reg;
        cache_next = cache_reg;
        req_next   = req_reg;
        scan_next  = scan_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = top_m2[AW-1:0];
        wr_en      = 1'b0;
        wr_addr    = top_m1[AW-1:0];
        wr_data    = set_code;
        ld         = 1'b0;
        ld_ev      = EV_NONE;
        ld_st      = S_OK;
        ld_len     = '0;
        sc         = S_OK;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    // fetch the entry under the top in case the token pops
                    q_pop      = 1'b1;
                    req_next   = q_data;
                    rd_en      = 1'b1;
                    state_next = BK_EXEC;
                end
            end
            BK_EXEC:
            begin
                if (req_reg.func)
                begin
                    sc = ctx_scan_status(cache_reg);
                    if (top_reg <= TW'(1))
                    begin
                        ld_st = S_OK;
                        if (out_free)
                        begin
                            ld         = 1'b1;
                            state_next = BK_IDLE;
                        end
                    end
                    else if (sc != S_OK || top_m1 == TW'(1))
                    begin
                        ld_st = (sc != S_OK) ? sc : S_INTERNAL;
                        if (out_free)
                        begin
                            ld         = 1'b1;
                            state_next = BK_IDLE;
                        end
                    end
                    else
                    begin
                        scan_next  = top_m2[AW-1:0];
                        state_next = BK_SCAN_RD;
                    end
                end
                else if (!x_res || out_free)
                begin
                    ld         = x_res;
                    ld_ev      = x_ev;
                    ld_st      = x_st;
                    ld_len     = req_reg.len;
                    state_next = BK_IDLE;
                    if (push_req && !at_full)
                    begin
                        wr_en      = 1'b1;
                        top_next   = top_reg + TW'(1);
                        cache_next = push_code;
                    end
                    else if (pop)
                    begin
                        top_next   = top_m1;
                        cache_next = rd_data_reg;
                    end
                    else
                    begin
                        cache_next = set_code;
                    end
                end
            end
            BK_SCAN_RD:
            begin
                rd_en      = 1'b1;
                rd_addr    = scan_reg;
                state_next = BK_SCAN_EV;
            end
            BK_SCAN_EV:
            begin
                sc = ctx_scan_status(rd_data_reg);
                if (sc != S_OK || scan_reg == AW'(1))
                begin
                    ld_st = (sc != S_OK) ? sc : S_INTERNAL;
                    if (out_free)
                    begin
                        ld         = 1'b1;
                        state_next = BK_IDLE;
                    end
                end
                else
                begin
                    scan_next  = scan_reg - AW'(1);
                    state_next = BK_SCAN_RD;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

    assign out_valid_next = ld ? 1'b1 : (m_axis_tready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            top_reg       <= TW'(1);
            cache_reg     <= ST_VALUE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            top_reg       <= top_next;
            cache_reg     <= cache_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg  <= req_next;
        scan_reg <= scan_next;
        if (ld)
        begin
            out_ev_reg  <= ld_ev;
            out_st_reg  <= ld_st;
            out_len_reg <= ld_len;
        end
    end

    // stack memory, one write and one registered read
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            ctx_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= ctx_mem[rd_addr];
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_len_reg;
    assign m_axis_tuser  = {1'b0, out_st_reg, out_ev_reg};

endmodule

FILE: rtl/json_token_structure_parser_top.sv
// a token result passes the front queue, the request register and the output register
// the stack engine takes one token at a time, in a fetch state and then an execute state
// end-of-input check: walks the stack down from the top, one read and one check per entry
// reset: stack holds only the root value context, queue and output register are empty
// the stack memory is not cleared; the live count keeps every used read on a written entry
module json_token_structure_parser_top #(
    parameter int STACK_DEPTH = jtsp_pkg::STACK_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    // token requests in
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // token_length[15:0]
    input  logic [7:0]  s_axis_tuser,   // func[0], token_kind[4:1], partial[5], zero[7:6]
    // structure events out
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // length[15:0]
    output logic [7:0]  m_axis_tuser    // event_kind[3:0], status[6:4], zero[7]
);
    import jtsp_pkg::*;

    // request handed from the classifying front to the stack engine
    req_t q_data;
    logic q_valid;
    logic q_pop;

    // front: takes requests, decodes the token kind, buffers in a short queue
    jtsp_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_data        (q_data),
        .q_valid       (q_valid),
        .q_pop         (q_pop)
    );

    // back: context stack with the top entry cached in a register,
    // end-of-input walk, and the output register
    jtsp_back #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_data        (q_data),
        .q_valid       (q_valid),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

FILE: rtl/jtsp_checker.sv
module jtsp_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,
    input  logic [7:0]  m_axis_tuser
);
    import jtsp_pkg::*;

    // requests accepted but not yet answered (silent ones stay counted)
    logic [31:0] credit_reg, credit_next;
    logic        in_acc, out_acc;
    logic [STAT_W-1:0] st;
    logic [KIND_W-1:0] ev;

    assign in_acc = s_axis_tvalid && s_axis_tready;
    assign out_acc = m_axis_tvalid && m_axis_tready;
    assign st = m_axis_tuser[6:4];
    assign ev = m_axis_tuser[3:0];

    always_comb
    begin
        credit_next = credit_reg;
        if (in_acc && !out_acc)
        begin
            credit_next = credit_reg + 32'd1;
        end
        else if (!in_acc && out_acc)
        begin
            credit_next = credit_reg - 32'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            credit_reg <= '0;
        end
        else
        begin
            credit_reg <= credit_next;
        end
    end

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // no result without an earlier request
    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> credit_reg != 32'd0)
        else $error("result without a pending request");

    // error results carry no event
    a_err_none: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && st >= S_INVALID |-> ev == EV_NONE)
        else $error("error result with an event");

    // unclosed reports come only from the end check, which has zero length
    a_uncl_len: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (st == S_UNCL_OBJ || st == S_UNCL_ARR) |-> m_axis_tdata == 16'd0)
        else $error("unclosed report with nonzero length");

endmodule

bind json_token_structure_parser_top jtsp_checker u_jtsp_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

FILE: tb/json_token_structure_parser_top_tb.sv
`timescale 1ns / 1ps

module json_token_structure_parser_top_tb;

    import jtsp_pkg::*;

    // request fields the package leaves unnamed
    localparam logic              FUNC_TOKEN = 1'b0;
    localparam logic              FUNC_END   = 1'b1;
    localparam logic [KIND_W-1:0] TK_NULL    = 4'd0;
    localparam logic [KIND_W-1:0] TK_TRUE    = 4'd1;
    localparam logic [KIND_W-1:0] TK_FALSE   = 4'd2;
    localparam logic [KIND_W-1:0] TK_OTHER   = 4'd11;
    localparam logic [KIND_W-1:0] TK_TOP     = 4'd15;

    // run shape
    localparam int RANDOM_ITEMS  = 100;
    localparam int HOLD_CYCLES   = 300;   // long receiver hold-off
    localparam int QUIET_LIMIT   = 3000;  // cycles with no handshake before giving up
    localparam int SETTLE_CYCLES = 50;

    // one structure event as seen on the output stream
    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [STAT_W-1:0] status;
        logic [LEN_W-1:0]  len;
    } parse_event_t;

    // tracks the parser context stack and holds the events still owed by the block
    class json_event_checker;
        logic [CODE_W-1:0] ctx_stack [STACK_DEPTH_DEF];
        int unsigned       depth;
        parse_event_t      expected_events [$];
        int                errors;

        function new();
            foreach (ctx_stack[i])
                ctx_stack[i] = ST_VALUE;
            depth  = 1;
            errors = 0;
        endfunction

        function bit push_ctx(logic [CODE_W-1:0] code);
            if (depth >= STACK_DEPTH_DEF)
                return 1'b0;
            ctx_stack[depth] = code;
            depth++;
            return 1'b1;
        endfunction

        function void set_top(logic [CODE_W-1:0] code);
            if (depth >= 1 && depth <= STACK_DEPTH_DEF)
                ctx_stack[depth-1] = code;
        endfunction

        // a value is expected: scalars and opening brackets are fine, the rest is invalid
        function logic [STAT_W-1:0] take_value(logic [KIND_W-1:0] kind, logic part,
                                               output logic [KIND_W-1:0] ev_kind);
            ev_kind = EV_NONE;
            if (kind <= TK_NUMBER) begin
                ev_kind = kind;
                if (part && !push_ctx(ST_PARTIAL))
                    return S_DEEP;
                return part ? S_MORE : S_OK;
            end
            if (kind == TK_OBJ_OPEN || kind == TK_ARR_OPEN) begin
                ev_kind = kind;
                if (!push_ctx(kind == TK_OBJ_OPEN ? ST_OBJ_NEW : ST_ARR_NEW))
                    return S_DEEP;
                return part ? S_MORE : S_OK;
            end
            return S_INVALID;
        endfunction

        // end of input: first scope found walking down from the top decides
        function logic [STAT_W-1:0] open_scope_status();
            int i;
            if (depth <= 1)
                return S_OK;
            for (i = int'(depth) - 1; i >= 1; i--) begin
                if (ctx_stack[i] == ST_VALUE || ctx_stack[i] == ST_PARTIAL)
                    continue;
                if (ctx_stack[i] >= ST_OBJ_NEW && ctx_stack[i] <= ST_OBJ_NEXT)
                    return S_UNCL_OBJ;
                if (ctx_stack[i] >= ST_ARR_NEW && ctx_stack[i] <= ST_ARR_NEXT)
                    return S_UNCL_ARR;
                return S_INTERNAL;
            end
            return S_INTERNAL;
        endfunction

        function void note_request(logic func, logic [KIND_W-1:0] kind, logic part,
                                   logic [LEN_W-1:0] len);
            parse_event_t      ev;
            logic [CODE_W-1:0] st;
            logic [STAT_W-1:0] s;
            ev.kind   = EV_NONE;
            ev.status = S_OK;
            ev.len    = len;
            s         = S_OK;
            if (func == FUNC_END) begin
                ev.status = open_scope_status();
                ev.len    = '0;
                expected_events.push_back(ev);
                return;
            end
            if (depth == 0 || depth > STACK_DEPTH_DEF) begin
                s = S_INTERNAL;
            end else begin
                st = ctx_stack[depth-1];
                case (st)
                    ST_VALUE:
                        s = take_value(kind, part, ev.kind);
                    ST_PARTIAL:
                    begin
                        // final chunk closes the scalar whatever its kind
                        if (!part)
                            depth--;
                        if (kind <= TK_NUMBER) begin
                            ev.kind = kind;
                            s = part ? S_MORE : S_OK;
                        end else begin
                            s = S_INTERNAL;
                        end
                    end
                    ST_OBJ_NEW, ST_OBJ_NEXT:
                    begin
                        if (st == ST_OBJ_NEW && kind == TK_OBJ_CLOSE) begin
                            depth--;
                            ev.kind = EV_OBJ_END;
                            s = S_OK;
                        end else if (kind == TK_STRING) begin
                            ev.kind = TK_STRING;
                            set_top(ST_OBJ_KEY);
                            s = part ? S_MORE : S_OK;
                            if (part && !push_ctx(ST_PARTIAL))
                                s = S_DEEP;
                        end else begin
                            s = S_BADKEY;
                        end
                    end
                    ST_OBJ_KEY:
                    begin
                        // colon after a key moves on silently
                        if (kind == TK_COLON) begin
                            set_top(ST_OBJ_COLON);
                            return;
                        end
                        s = S_INVALID;
                    end
                    ST_OBJ_COLON:
                    begin
                        set_top(ST_OBJ_VALUE);
                        s = take_value(kind, part, ev.kind);
                    end
                    ST_OBJ_VALUE, ST_ARR_ITEM:
                    begin
                        // comma after a member or item moves on silently
                        if (kind == TK_COMMA) begin
                            set_top(st == ST_OBJ_VALUE ? ST_OBJ_NEXT : ST_ARR_NEXT);
                            return;
                        end
                        if (kind == (st == ST_OBJ_VALUE ? TK_OBJ_CLOSE : TK_ARR_CLOSE)) begin
                            depth--;
                            ev.kind = (st == ST_OBJ_VALUE) ? EV_OBJ_END : EV_ARR_END;
                            s = S_OK;
                        end else begin
                            s = S_INVALID;
                        end
                    end
                    ST_ARR_NEW:
                    begin
                        if (kind == TK_ARR_CLOSE) begin
                            depth--;
                            ev.kind = EV_ARR_END;
                            s = S_OK;
                        end else begin
                            set_top(ST_ARR_ITEM);
                            s = take_value(kind, part, ev.kind);
                        end
                    end
                    ST_ARR_NEXT:
                    begin
                        set_top(ST_ARR_ITEM);
                        s = take_value(kind, part, ev.kind);
                    end
                    default:
                        s = S_INTERNAL;
                endcase
            end
            if (s >= S_INVALID)
                ev.kind = EV_NONE;
            ev.status = s;
            expected_events.push_back(ev);
        endfunction

        function void check_event(logic [KIND_W-1:0] kind, logic [STAT_W-1:0] status,
                                  logic [LEN_W-1:0] len);
            parse_event_t want;
            if (expected_events.size() == 0) begin
                $display("%0t: event with none expected: kind %0d status %0d length %0d",
                         $time, kind, status, len);
                errors++;
                return;
            end
            want = expected_events.pop_front();
            if (kind !== want.kind) begin
                $display("%0t: event_kind expected %0d actual %0d", $time, want.kind, kind);
                errors++;
            end
            if (status !== want.status) begin
                $display("%0t: status expected %0d actual %0d", $time, want.status, status);
                errors++;
            end
            if (len !== want.len) begin
                $display("%0t: length expected %0d actual %0d", $time, want.len, len);
                errors++;
            end
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata = '0;    // token_length[15:0]
    logic [7:0]  s_axis_tuser = '0;    // func[0], token_kind[4:1], partial[5], zero[7:6]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // length[15:0]
    logic [7:0]  m_axis_tuser;         // event_kind[3:0], status[6:4], zero[7]

    json_event_checker events_chk = new();

    int quiet_cycles = 0;
    int items_sent   = 0;
    int src_gap_pct  = 30;   // chance of an idle gap after each request
    int sink_gap_pct = 30;   // chance of a stall on the result side
    bit hold_events  = 1'b0; // asks the sink for one long hold-off
    bit src_offering = 1'b0; // tvalid is (or is about to be) high

    json_token_structure_parser_top u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // idle lengths: mostly short, now and then long
    function automatic int pause_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            return $urandom_range(1, 2);
        if (r < 90)
            return $urandom_range(3, 8);
        return $urandom_range(20, 80);
    endfunction

    // token lengths, with both extremes showing up often
    function automatic logic [LEN_W-1:0] rand_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return '0;
        if (r < 20)
            return '1;
        return LEN_W'($urandom());
    endfunction

    // result side: every accepted event goes to the checker
    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            events_chk.check_event(m_axis_tuser[KIND_W-1:0],
                                   m_axis_tuser[KIND_W+STAT_W-1:KIND_W], m_axis_tdata);

    // count cycles with no handshake on either side
    always @(posedge clk)
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;

    initial begin : watchdog
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("json_token_structure_parser_top: mismatch");
        $finish;
    end

    // result sink: random stalls, plus one long hold-off on request
    initial begin : event_sink
        wait (rst_n);
        forever begin
            @(posedge clk);
            if (hold_events) begin
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_events = 1'b0;
                m_axis_tready <= 1'b1;
            end else if ($urandom_range(0, 99) < sink_gap_pct) begin
                m_axis_tready <= 1'b0;
                repeat (pause_len()) @(posedge clk);
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
            end
        end
    end

    // offer one request and hold it until taken; valid stays up when no gap follows
    task automatic send_token(input logic func, input logic [KIND_W-1:0] kind,
                              input logic part, input logic [LEN_W-1:0] len);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= len;
        s_axis_tuser  <= {2'b00, part, kind, func};
        src_offering = 1'b1;
        do
            @(posedge clk);
        while (!s_axis_tready);
        events_chk.note_request(func, kind, part, len);
        items_sent++;
        gap = ($urandom_range(0, 99) < src_gap_pct) ? pause_len() : 0;
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            src_offering = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        if (src_offering) begin
            s_axis_tvalid <= 1'b0;
            src_offering = 1'b0;
        end
    endtask

    // sender pause until the block has answered everything
    task automatic wait_for_drain();
        stop_sending();
        while (events_chk.expected_events.size() != 0)
            @(posedge clk);
    endtask

    // end-of-input check; the token fields ride along at random
    task automatic end_check();
        send_token(FUNC_END, KIND_W'($urandom()), 1'($urandom()), rand_len());
    endtask

    // one token, replaced by a fully random request with the given chance
    task automatic feed(input logic [KIND_W-1:0] kind, input logic part, input int noise);
        if (noise > 0 && $urandom_range(0, 99) < noise)
            send_token(($urandom_range(0, 99) < 15) ? FUNC_END : FUNC_TOKEN,
                       KIND_W'($urandom()), 1'($urandom()), rand_len());
        else
            send_token(FUNC_TOKEN, kind, part, rand_len());
    endtask

    // scalar, sometimes split into partial chunks before the final one
    task automatic send_scalar(input logic [KIND_W-1:0] kind, input int noise);
        int chunks;
        chunks = ($urandom_range(0, 99) < 25) ? $urandom_range(1, 3) : 0;
        repeat (chunks) feed(kind, 1'b1, noise);
        feed(kind, 1'b0, noise);
    endtask

    // well-formed json value with random shape, nested up to four scopes
    task automatic send_json_value(input int noise);
        bit scope_is_obj [$];
        int scope_left [$];
        bit scope_started [$];
        bit need_value;
        bit is_obj;
        int pick;
        int t;
        need_value = 1'b1;
        while (need_value) begin
            pick = $urandom_range(0, 99);
            if (scope_left.size() >= 4 || pick < 45) begin
                send_scalar(KIND_W'($urandom_range(TK_NULL, TK_NUMBER)), noise);
            end else begin
                is_obj = (pick < 72);
                feed(is_obj ? TK_OBJ_OPEN : TK_ARR_OPEN, $urandom_range(0, 99) < 10, noise);
                scope_is_obj.push_back(is_obj);
                scope_left.push_back($urandom_range(0, 3));
                scope_started.push_back(1'b0);
            end
            need_value = 1'b0;
            // close every scope that has all its members
            while (scope_left.size() != 0 && scope_left[scope_left.size()-1] == 0) begin
                feed(scope_is_obj[scope_is_obj.size()-1] ? TK_OBJ_CLOSE : TK_ARR_CLOSE,
                     $urandom_range(0, 99) < 10, noise);
                void'(scope_is_obj.pop_back());
                void'(scope_left.pop_back());
                void'(scope_started.pop_back());
            end
            if (scope_left.size() != 0) begin
                t = scope_left.size() - 1;
                if (scope_started[t])
                    feed(TK_COMMA, $urandom_range(0, 99) < 10, noise);
                scope_started[t] = 1'b1;
                scope_left[t]--;
                if (scope_is_obj[t]) begin
                    send_scalar(TK_STRING, noise);
                    feed(TK_COLON, $urandom_range(0, 99) < 10, noise);
                end
                need_value = 1'b1;
            end
        end
    endtask

    // bring the parser back to the root by finishing whatever scope is on top
    task automatic return_to_root();
        logic [CODE_W-1:0] code;
        while (events_chk.depth > 1) begin
            code = events_chk.ctx_stack[events_chk.depth-1];
            case (code)
                ST_PARTIAL:                 feed(TK_STRING, 1'b0, 0);
                ST_OBJ_NEW, ST_OBJ_VALUE:   feed(TK_OBJ_CLOSE, 1'b0, 0);
                ST_OBJ_NEXT:                feed(TK_STRING, 1'b0, 0);
                ST_OBJ_KEY:                 feed(TK_COLON, 1'b0, 0);
                ST_OBJ_COLON, ST_ARR_NEXT:  feed(TK_NULL, 1'b0, 0);
                ST_ARR_NEW, ST_ARR_ITEM:    feed(TK_ARR_CLOSE, 1'b0, 0);
                default:                    return;
            endcase
        end
    endtask

    initial begin : stimulus
        int pick;
        int random_start;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: root values, partial chunks and their misuse
        end_check();                                              // nothing open
        send_token(FUNC_TOKEN, TK_NULL, 1'b0, 16'h0000);
        send_token(FUNC_TOKEN, TK_TRUE, 1'b0, 16'hffff);
        send_token(FUNC_TOKEN, TK_NUMBER, 1'b1, 16'h0000);        // chunk, more to come
        end_check();                                              // only a partial scalar open
        send_token(FUNC_TOKEN, TK_NUMBER, 1'b0, 16'hffff);        // final chunk
        send_token(FUNC_TOKEN, TK_STRING, 1'b1, 16'h1234);
        send_token(FUNC_TOKEN, TK_OBJ_OPEN, 1'b0, 16'h8000);      // bracket inside a scalar
        send_token(FUNC_TOKEN, TK_OTHER, 1'b0, 16'h0001);         // other kind at the root
        send_token(FUNC_TOKEN, TK_TOP, 1'b1, 16'h7fff);
        send_token(FUNC_TOKEN, TK_ARR_CLOSE, 1'b0, 16'h0002);     // closing with nothing open

        // directed: object and array rules, partial flag on brackets
        send_token(FUNC_TOKEN, TK_OBJ_OPEN, 1'b1, 16'h00ff);
        end_check();
        send_token(FUNC_TOKEN, TK_NUMBER, 1'b0, 16'h0003);        // key must be a string
        send_token(FUNC_TOKEN, TK_STRING, 1'b0, 16'h0004);
        send_token(FUNC_TOKEN, TK_FALSE, 1'b0, 16'h0005);         // colon missing
        send_token(FUNC_TOKEN, TK_COLON, 1'b1, 16'h0006);
        send_token(FUNC_TOKEN, TK_ARR_OPEN, 1'b0, 16'h0007);
        end_check();                                              // array on top of object
        send_token(FUNC_TOKEN, TK_ARR_CLOSE, 1'b1, 16'h0008);     // empty array
        send_token(FUNC_TOKEN, TK_COMMA, 1'b0, 16'h0009);
        send_token(FUNC_TOKEN, TK_OBJ_CLOSE, 1'b0, 16'h000a);     // close right after a comma
        send_token(FUNC_TOKEN, TK_STRING, 1'b0, 16'h000b);
        send_token(FUNC_TOKEN, TK_COLON, 1'b0, 16'h000c);
        send_token(FUNC_TOKEN, TK_ARR_OPEN, 1'b0, 16'h000d);
        send_token(FUNC_TOKEN, TK_TRUE, 1'b0, 16'h000e);
        send_token(FUNC_TOKEN, TK_COMMA, 1'b0, 16'h000f);
        send_token(FUNC_TOKEN, TK_COMMA, 1'b0, 16'h0010);         // double comma
        send_token(FUNC_TOKEN, TK_OBJ_CLOSE, 1'b0, 16'h0011);     // wrong bracket
        send_token(FUNC_TOKEN, TK_ARR_CLOSE, 1'b0, 16'h0012);
        send_token(FUNC_TOKEN, TK_OBJ_CLOSE, 1'b0, 16'h0013);

        // stack overflow with an object on top: key, then value, cannot be pushed
        repeat (STACK_DEPTH_DEF - 2) feed(TK_ARR_OPEN, 1'b0, 0);
        feed(TK_OBJ_OPEN, 1'b0, 0);
        feed(TK_STRING, 1'b1, 0);
        feed(TK_COLON, 1'b0, 0);
        feed(TK_ARR_OPEN, 1'b0, 0);
        end_check();                                              // object open at the top
        feed(TK_COMMA, 1'b0, 0);
        return_to_root();

        // stack overflow with an array on top: partial scalar cannot be pushed
        repeat (STACK_DEPTH_DEF - 1) feed(TK_ARR_OPEN, 1'b0, 0);
        feed(TK_NULL, 1'b1, 0);
        end_check();
        return_to_root();

        // back-pressure: results held off while the sender keeps offering
        hold_events = 1'b1;
        repeat (8) send_scalar(KIND_W'($urandom_range(TK_NULL, TK_NUMBER)), 0);
        wait_for_drain();

        // random part: mostly well-formed values, some noisy, broken or raw
        random_start = items_sent;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            if ($urandom_range(0, 99) < 15) begin
                case ($urandom_range(0, 2))
                    0:       src_gap_pct = 0;
                    1:       src_gap_pct = 20;
                    default: src_gap_pct = 50;
                endcase
                case ($urandom_range(0, 2))
                    0:       sink_gap_pct = 0;
                    1:       sink_gap_pct = 25;
                    default: sink_gap_pct = 50;
                endcase
            end
            pick = $urandom_range(0, 99);
            if (pick < 55) begin
                send_json_value(0);
                if ($urandom_range(0, 99) < 30)
                    end_check();
            end else if (pick < 72) begin
                send_json_value(8);
                end_check();
                return_to_root();
            end else if (pick < 84) begin
                // value cut short before its scopes are closed
                repeat ($urandom_range(1, 4)) begin
                    if ($urandom_range(0, 1)) begin
                        feed(TK_ARR_OPEN, 1'b0, 0);
                    end else begin
                        feed(TK_OBJ_OPEN, 1'b0, 0);
                        send_scalar(TK_STRING, 0);
                        feed(TK_COLON, 1'b0, 0);
                    end
                end
                if ($urandom_range(0, 1))
                    feed(KIND_W'($urandom_range(TK_NULL, TK_NUMBER)), 1'b1, 0);
                end_check();
                return_to_root();
            end else if (pick < 95) begin
                repeat ($urandom_range(1, 6)) feed(TK_OTHER, 1'b0, 100);
                return_to_root();
            end else begin
                wait_for_drain();
            end
        end

        wait_for_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (events_chk.errors == 0 && events_chk.expected_events.size() == 0)
            $display("json_token_structure_parser_top: match");
        else
            $display("json_token_structure_parser_top: mismatch");
        $finish;
    end

endmodule
